### sv/mvt_pkg.sv
// Shared types, constants and helpers for the 4x4 matrix-vector transform.
package mvt_pkg;

  localparam int DATA_WIDTH_DEF = 32;
  localparam int COEF_WIDTH_DEF = 16;
  localparam int FRAC_BITS      = 12;
  localparam int FIELD_W        = 32;
  localparam int LANE_W         = 16;
  localparam int NUM_ROWS       = 4;
  localparam int NUM_COLS       = 4;
  localparam int CFG_W          = 64;
  localparam int ADDR_W         = 5;
  localparam int IDX_LSB        = 3;

  typedef enum logic [1:0] {
    REG_ROW0 = 2'd0,
    REG_ROW1 = 2'd1,
    REG_ROW2 = 2'd2,
    REG_ROW3 = 2'd3
  } reg_idx_t;

  typedef struct packed {
    logic signed [FIELD_W-1:0] vin_x;
    logic signed [FIELD_W-1:0] vin_y;
    logic signed [FIELD_W-1:0] vin_z;
    logic signed [FIELD_W-1:0] vin_w;
  } vec_in_t;

  typedef struct packed {
    logic signed [FIELD_W-1:0] vout_x;
    logic signed [FIELD_W-1:0] vout_y;
    logic signed [FIELD_W-1:0] vout_z;
    logic signed [FIELD_W-1:0] vout_w;
    logic                      saturated;
  } vec_out_t;

  // Identity row: 1.0 in Q4.12 on the diagonal lane.
  function automatic logic [CFG_W-1:0] row_reset(input reg_idx_t idx);
    logic [CFG_W-1:0] one;
    one = CFG_W'(16'h1000);
    return one << (LANE_W * int'(idx));
  endfunction

endpackage

### sv/mvt_row_mul.sv
// Product stage: four registered coefficient-by-component products of one row.
module mvt_row_mul #(
  parameter int DATA_WIDTH = mvt_pkg::DATA_WIDTH_DEF,
  parameter int COEF_WIDTH = mvt_pkg::COEF_WIDTH_DEF,
  parameter int PROD_W     = DATA_WIDTH + COEF_WIDTH
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_vld,
  input  mvt_pkg::vec_in_t             vec,
  input  logic [mvt_pkg::CFG_W-1:0]    coefs,
  output logic                         out_vld,
  output logic signed [PROD_W-1:0]     prod [mvt_pkg::NUM_COLS]
);

  localparam int EXT_W = (DATA_WIDTH > mvt_pkg::FIELD_W) ? DATA_WIDTH : mvt_pkg::FIELD_W;

  logic [mvt_pkg::FIELD_W-1:0] fld [mvt_pkg::NUM_COLS];
  logic                        vld_r;
  logic signed [PROD_W-1:0]    prod_r   [mvt_pkg::NUM_COLS];
  logic signed [PROD_W-1:0]    prod_nxt [mvt_pkg::NUM_COLS];

  assign fld[0] = vec.vin_x;
  assign fld[1] = vec.vin_y;
  assign fld[2] = vec.vin_z;
  assign fld[3] = vec.vin_w;

  for (genvar j = 0; j < mvt_pkg::NUM_COLS; j++) begin : g_col
    logic [EXT_W-1:0]             ext;
    logic signed [DATA_WIDTH-1:0] opd;
    logic signed [COEF_WIDTH-1:0] cf;

    // A field narrower than the datapath is taken as an unsigned pattern.
    assign ext         = EXT_W'(fld[j]);
    assign opd         = signed'(ext[DATA_WIDTH-1:0]);
    assign cf          = signed'(coefs[mvt_pkg::LANE_W*j +: COEF_WIDTH]);
    assign prod_nxt[j] = opd * cf;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= in_vld;
    end
  end

  always_ff @(posedge clk) begin
    prod_r <= prod_nxt;
  end

  assign out_vld = vld_r;
  assign prod    = prod_r;

endmodule

### sv/mvt_row_acc.sv
// Accumulate stages: pair sums, row sum, then shift and saturate one row.
module mvt_row_acc #(
  parameter int DATA_WIDTH = mvt_pkg::DATA_WIDTH_DEF,
  parameter int COEF_WIDTH = mvt_pkg::COEF_WIDTH_DEF,
  parameter int PROD_W     = DATA_WIDTH + COEF_WIDTH
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_vld,
  input  logic signed [PROD_W-1:0]     prod [mvt_pkg::NUM_COLS],
  output logic                         out_vld,
  output logic signed [DATA_WIDTH-1:0] res,
  output logic                         sat
);

  localparam int PAIR_W = PROD_W + 1;
  localparam int SUM_W  = PROD_W + 2;
  localparam int SHR_W  = SUM_W - mvt_pkg::FRAC_BITS;
  localparam int CMP_W  = (SHR_W > DATA_WIDTH) ? SHR_W : DATA_WIDTH + 1;
  localparam logic signed [CMP_W-1:0] MAXV =
    {{(CMP_W-DATA_WIDTH+1){1'b0}}, {(DATA_WIDTH-1){1'b1}}};
  localparam logic signed [CMP_W-1:0] MINV =
    {{(CMP_W-DATA_WIDTH+1){1'b1}}, {(DATA_WIDTH-1){1'b0}}};

  logic                         vld_a_r, vld_b_r, vld_c_r;
  logic signed [PAIR_W-1:0]     pair0_r, pair1_r;
  logic signed [SUM_W-1:0]      sum_r;
  logic signed [SHR_W-1:0]      shr;
  logic signed [CMP_W-1:0]      wide;
  logic signed [DATA_WIDTH-1:0] res_r, res_nxt;
  logic                         sat_r, sat_nxt;

  // Dropping the low fraction bits of a two's complement sum floors it.
  assign shr  = signed'(sum_r[SUM_W-1:mvt_pkg::FRAC_BITS]);
  assign wide = CMP_W'(shr);

  always_comb begin
    unique if (wide > MAXV) begin
      res_nxt = MAXV[DATA_WIDTH-1:0];
      sat_nxt = 1'b1;
    end else if (wide < MINV) begin
      res_nxt = MINV[DATA_WIDTH-1:0];
      sat_nxt = 1'b1;
    end else begin
      res_nxt = wide[DATA_WIDTH-1:0];
      sat_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_a_r <= 1'b0;
      vld_b_r <= 1'b0;
      vld_c_r <= 1'b0;
    end else begin
      vld_a_r <= in_vld;
      vld_b_r <= vld_a_r;
      vld_c_r <= vld_b_r;
    end
  end

  always_ff @(posedge clk) begin
    pair0_r <= PAIR_W'(prod[0]) + PAIR_W'(prod[1]);
    pair1_r <= PAIR_W'(prod[2]) + PAIR_W'(prod[3]);
    sum_r   <= SUM_W'(pair0_r) + SUM_W'(pair1_r);
    res_r   <= res_nxt;
    sat_r   <= sat_nxt;
  end

  assign out_vld = vld_c_r;
  assign res     = res_r;
  assign sat     = sat_r;

  a_sat_at_limit: assert property (@(posedge clk) disable iff (!rst_n)
    vld_c_r && sat_r |-> (res_r == MAXV[DATA_WIDTH-1:0]) || (res_r == MINV[DATA_WIDTH-1:0]))
    else $error("saturation flag set but result is not a range limit");

  a_vld_depth: assert property (@(posedge clk) disable iff (!rst_n)
    in_vld |-> ##3 out_vld)
    else $error("valid lost in accumulate stages");

endmodule

### sv/matrix_vector_transform_4x4.sv
// Top level of the 4x4 fixed-point matrix-vector transform with its register port.
// Pipeline: a word accepted on the in_ ports passes the multiply register,
//   two adder levels and the saturate register before its result shows on
//   the out_ ports.
// Throughput: one word per cycle; busy never rises, since all four rows have
//   their own pipelined multipliers and adders.
// Reset (rst_n low, synchronous) clears all pipeline valid bits and loads the
//   identity matrix into the four row registers.
module matrix_vector_transform_4x4 #(
  parameter int DATA_WIDTH = mvt_pkg::DATA_WIDTH_DEF,
  parameter int COEF_WIDTH = mvt_pkg::COEF_WIDTH_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  // Input words.
  input  logic                         start,
  output logic                         busy,
  input  mvt_pkg::vec_in_t             in_word,
  // Result words, one-cycle strobe.
  output logic                         out_valid,
  output mvt_pkg::vec_out_t            out_word,
  // Register port.
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [mvt_pkg::ADDR_W-1:0]   paddr,
  input  logic [mvt_pkg::CFG_W-1:0]    pwdata,
  output logic [mvt_pkg::CFG_W-1:0]    prdata,
  output logic                         pready
);

  localparam int PROD_W = DATA_WIDTH + COEF_WIDTH;
  localparam int OUT_EXT_W = (DATA_WIDTH > mvt_pkg::FIELD_W) ? DATA_WIDTH : mvt_pkg::FIELD_W;

  // Matrix rows. Each 64-bit register holds four 16-bit coefficient lanes;
  // lane j multiplies component j (x, y, z, w) of the incoming word.
  logic [mvt_pkg::CFG_W-1:0] coef_r [mvt_pkg::NUM_ROWS];
  mvt_pkg::reg_idx_t         reg_idx;
  logic                      cfg_wr;
  logic                      accept;

  logic                         mul_vld [mvt_pkg::NUM_ROWS];
  logic                         row_vld [mvt_pkg::NUM_ROWS];
  logic signed [DATA_WIDTH-1:0] row_res [mvt_pkg::NUM_ROWS];
  logic [mvt_pkg::NUM_ROWS-1:0] row_vld_vec;
  logic [mvt_pkg::NUM_ROWS-1:0] row_sat;
  logic [mvt_pkg::FIELD_W-1:0]  row_out [mvt_pkg::NUM_ROWS];

  // The block never stalls, so every start is taken.
  assign busy   = 1'b0;
  assign accept = start && !busy;

  // Registers sit 8 bytes apart; the low address bits only select bytes.
  assign reg_idx = mvt_pkg::reg_idx_t'(paddr[mvt_pkg::ADDR_W-1:mvt_pkg::IDX_LSB]);
  assign cfg_wr  = psel && penable && pwrite && pready;
  assign pready  = 1'b1;
  assign prdata  = coef_r[reg_idx];

  for (genvar i = 0; i < mvt_pkg::NUM_ROWS; i++) begin : g_cfg
    always_ff @(posedge clk) begin
      if (!rst_n) begin
        coef_r[i] <= mvt_pkg::row_reset(mvt_pkg::reg_idx_t'(i));
      end else if (cfg_wr && (reg_idx == mvt_pkg::reg_idx_t'(i))) begin
        coef_r[i] <= pwdata;
      end
    end
  end

  // One independent four-stage pipeline per matrix row. The rows run in
  // lockstep, so their valid bits always agree.
  for (genvar i = 0; i < mvt_pkg::NUM_ROWS; i++) begin : g_row
    logic signed [PROD_W-1:0]    prod [mvt_pkg::NUM_COLS];
    logic signed [OUT_EXT_W-1:0] res_ext;

    mvt_row_mul #(
      .DATA_WIDTH (DATA_WIDTH),
      .COEF_WIDTH (COEF_WIDTH),
      .PROD_W     (PROD_W)
    ) u_mul (
      .clk     (clk),
      .rst_n   (rst_n),
      .in_vld  (accept),
      .vec     (in_word),
      .coefs   (coef_r[i]),
      .out_vld (mul_vld[i]),
      .prod    (prod)
    );

    mvt_row_acc #(
      .DATA_WIDTH (DATA_WIDTH),
      .COEF_WIDTH (COEF_WIDTH),
      .PROD_W     (PROD_W)
    ) u_acc (
      .clk     (clk),
      .rst_n   (rst_n),
      .in_vld  (mul_vld[i]),
      .prod    (prod),
      .out_vld (row_vld[i]),
      .res     (row_res[i]),
      .sat     (row_sat[i])
    );

    // Results narrower than the field are sign-extended; wider ones keep
    // their low field bits.
    assign res_ext        = OUT_EXT_W'(row_res[i]);
    assign row_out[i]     = res_ext[mvt_pkg::FIELD_W-1:0];
    assign row_vld_vec[i] = row_vld[i];
  end

  assign out_valid = &row_vld_vec;

  always_comb begin
    out_word           = '0;
    out_word.vout_x    = row_out[0];
    out_word.vout_y    = row_out[1];
    out_word.vout_z    = row_out[2];
    out_word.vout_w    = row_out[3];
    out_word.saturated = |row_sat;
  end

  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    accept |-> ##4 out_valid)
    else $error("accepted word did not produce a result four cycles later");

  a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(start, 4) && $past(rst_n, 4))
    else $error("result strobe without a matching accepted word");

  a_rows_lockstep: assert property (@(posedge clk) disable iff (!rst_n)
    (row_vld_vec == '0) || (row_vld_vec == '1))
    else $error("row pipelines out of step");

endmodule
